FILE: rtl/core/sas_pkg.sv
package sas_pkg;

    // Number of aspect codes and lamp heads handled by the block.
    localparam int ASPECT_CODES = 8;
    localparam int HEAD_COUNT   = 8;

    // Bits of the configuration words that stand for real codes and heads.
    localparam logic [7:0] CODE_MASK  = 8'((1 << ASPECT_CODES) - 1);
    localparam logic [7:0] HEADS_MASK = 8'((1 << HEAD_COUNT) - 1);

    localparam logic [15:0] FLASH_INTERVAL_RESET = 16'd500;
    localparam logic [7:0]  DEFINED_RESET        = 8'h01;

    typedef enum logic [2:0] {
        CFG_DEFINED_ASPECTS = 3'd0,
        CFG_ON_HEAD_MASKS   = 3'd1,
        CFG_OFF_HEAD_MASKS  = 3'd2,
        CFG_FLASH_ASPECTS   = 3'd3,
        CFG_FLASH_INTERVAL  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_TURN_OFF = 2'd0,
        PH_WAIT_OFF = 2'd1,
        PH_FLASH    = 2'd2,
        PH_IDLE     = 2'd3
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [2:0] aspect_code;
        logic [7:0] heads_inactive;
    } in_item_t;

    typedef struct packed {
        logic       drive_valid;
        logic [7:0] drive_heads;
        logic       drive_level;
        logic       aspect_changed;
        logic [2:0] selected_aspect;
        logic [2:0] requested_aspect;
        logic [1:0] phase;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  defined_aspects;
        logic [63:0] on_head_masks;
        logic [63:0] off_head_masks;
        logic [7:0]  flash_aspects;
        logic [15:0] flash_interval_ticks;
    } cfg_regs_t;

    // Largest defined code not above the request, else the smallest defined
    // code, else code zero.
    function automatic logic [2:0] choose_aspect(logic [7:0] defined, logic [2:0] req);
        logic [7:0] d;
        logic [2:0] high_pick;
        logic [2:0] low_pick;
        logic       found;
        d         = defined & CODE_MASK;
        high_pick = '0;
        low_pick  = '0;
        found     = 1'b0;
        for (int c = 0; c < 8; c++) begin
            if (d[c] && (3'(c) <= req)) begin
                high_pick = 3'(c);
                found     = 1'b1;
            end
        end
        for (int c = 7; c >= 0; c--) begin
            if (d[c]) begin
                low_pick = 3'(c);
            end
        end
        return found ? high_pick : low_pick;
    endfunction

    // Head byte of one aspect, limited to the heads that exist.
    function automatic logic [7:0] head_byte(logic [63:0] masks, logic [2:0] code);
        return masks[{code, 3'b000} +: 8] & HEADS_MASK;
    endfunction

endpackage

FILE: rtl/core/signal_aspect_sequencer.sv
// An accepted request's result is registered in the result register, or in the skid entry.
// Throughput: one request per cycle while the skid entry is empty, set by combinational step
// logic; a two-entry output buffer keeps item_ready high while one result waits.
// Configuration writes are taken in every cycle and act from the next cycle on.
// Reset (rst_n low, asynchronous) restores the register defaults, empties the output
// buffer and clears the sequencer so that the next request adopts the lowest defined aspect.
module signal_aspect_sequencer
    import sas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel: aspect requests and millisecond ticks.
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    // Result channel: one result per accepted request.
    output logic        result_valid,
    input  logic        result_ready,
    output out_item_t   result,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_regs_t cfg;
    out_item_t step_result;
    logic      accept;
    logic      can_push;

    // A request is taken whenever the output buffer has a free entry.
    assign item_ready = can_push;
    assign accept     = item_valid && can_push;

    // Configuration registers, read live by every request.
    sas_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Aspect selection and lamp sequence; its state advances on each accepted request.
    sas_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .result (step_result)
    );

    // Result register with a skid entry behind it.
    sas_out_buf u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .can_push     (can_push),
        .push_data    (step_result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: rtl/core/sas_cfg_regs.sv
module sas_cfg_regs
    import sas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output cfg_regs_t   cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // Writes are always taken; the user must issue them only while the block is idle, as the block does not enforce it.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEFINED_ASPECTS: cfg_next.defined_aspects      = cfg_data[7:0];
                CFG_ON_HEAD_MASKS:   cfg_next.on_head_masks        = cfg_data;
                CFG_OFF_HEAD_MASKS:  cfg_next.off_head_masks       = cfg_data;
                CFG_FLASH_ASPECTS:   cfg_next.flash_aspects        = cfg_data[7:0];
                CFG_FLASH_INTERVAL:  cfg_next.flash_interval_ticks = cfg_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.defined_aspects      <= DEFINED_RESET;
            cfg_reg.on_head_masks        <= '0;
            cfg_reg.off_head_masks       <= '0;
            cfg_reg.flash_aspects        <= '0;
            cfg_reg.flash_interval_ticks <= FLASH_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/sas_step.sv
module sas_step
    import sas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  cfg_regs_t cfg,
    output out_item_t result
);

    phase_t      phase_reg,   phase_next;
    logic [2:0]  request_reg, request_next;
    logic [2:0]  select_reg,  select_next;
    logic        started_reg, started_next;
    logic        lit_reg,     lit_next;
    logic [15:0] count_reg,   count_next;

    logic [2:0]  low_code;
    logic [7:0]  off_mask;
    logic [7:0]  on_mask;
    logic [15:0] interval;
    logic [15:0] count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TURN_OFF;
            request_reg <= '0;
            select_reg  <= '0;
            started_reg <= 1'b0;
            lit_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            request_reg <= request_next;
            select_reg  <= select_next;
            started_reg <= started_next;
            lit_reg     <= lit_next;
            count_reg   <= count_next;
        end
    end

    assign low_code = choose_aspect(cfg.defined_aspects, 3'd0);
    assign interval = (cfg.flash_interval_ticks == 16'd0) ? 16'd1 : cfg.flash_interval_ticks;

    always_comb
    begin
        // The first item adopts the lowest defined aspect before it is handled.
        phase_next   = started_reg ? phase_reg   : PH_TURN_OFF;
        request_next = started_reg ? request_reg : low_code;
        select_next  = started_reg ? select_reg  : low_code;
        lit_next     = started_reg ? lit_reg     : 1'b0;
        count_next   = started_reg ? count_reg   : 16'd0;
        started_next = 1'b1;

        off_mask  = head_byte(cfg.off_head_masks, select_next);
        on_mask   = head_byte(cfg.on_head_masks, select_next);
        count_inc = count_next + 16'd1;

        result = '0;

        if (!item.mode)
        begin
            if (item.aspect_code != request_next)
            begin
                request_next          = item.aspect_code;
                select_next           = choose_aspect(cfg.defined_aspects, item.aspect_code);
                phase_next            = PH_TURN_OFF;
                result.aspect_changed = 1'b1;
            end
        end
        else
        begin
            unique case (phase_next)
                PH_TURN_OFF:
                begin
                    result.drive_valid = 1'b1;
                    result.drive_heads = off_mask;
                    phase_next         = PH_WAIT_OFF;
                end
                PH_WAIT_OFF:
                begin
                    if ((item.heads_inactive & off_mask) == off_mask)
                    begin
                        result.drive_valid = 1'b1;
                        result.drive_heads = on_mask;
                        result.drive_level = 1'b1;
                        if (cfg.flash_aspects[select_next])
                        begin
                            phase_next = PH_FLASH;
                            lit_next   = 1'b1;
                            count_next = 16'd0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_FLASH:
                begin
                    count_next = count_inc;
                    if (count_inc >= interval)
                    begin
                        lit_next           = ~lit_next;
                        result.drive_valid = 1'b1;
                        result.drive_heads = on_mask;
                        result.drive_level = lit_next;
                        count_next         = 16'd0;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result.selected_aspect  = select_next;
        result.requested_aspect = request_next;
        result.phase            = phase_next;
    end

`ifndef SYNTH
    a_started_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> started_reg)
        else $error("sequencer not started after an accepted item");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(select_reg) && $stable(count_reg))
        else $error("sequencer state moved without an accepted item");
`endif

endmodule

FILE: rtl/core/sas_out_buf.sv
module sas_out_buf
    import sas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      can_push,
    input  out_item_t push_data,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_data_reg;
    out_item_t skid_data_reg;
    logic      take;

    assign take         = out_valid_reg && result_ready;
    assign can_push     = !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while the output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !take |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid entry lost or overwritten");
`endif

endmodule
